// ===== hw/rtl/ebm_pkg.sv =====
package ebm_pkg;

   localparam int unsigned FUNC_W = 4;
   localparam int unsigned COST_W = 32;
   localparam int unsigned STEP_W = 17;
   localparam int unsigned LOOP_W = 14;
   localparam int unsigned CB_W = 11;
   localparam int unsigned REC_W = 7;
   localparam int unsigned BYTE_W = 32;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 5;

   localparam int unsigned POLL_INTERVAL_DEFAULT = 256;

   // Hard caps applied when budgets are loaded at begin-call.
   localparam logic [STEP_W-1:0] CAP_STEP = 17'd100000;
   localparam logic [LOOP_W-1:0] CAP_LOOP = 14'd10000;
   localparam logic [CB_W-1:0] CAP_CALLBACK = 11'd1024;
   localparam logic [REC_W-1:0] CAP_RECURSION = 7'd100;

   // Register values after reset.
   localparam logic [STEP_W-1:0] STEP_QUOTA_RESET = 17'd100000;
   localparam logic [LOOP_W-1:0] LOOP_QUOTA_RESET = 14'd10000;
   localparam logic [CB_W-1:0] CALLBACK_QUOTA_RESET = 11'd1024;
   localparam logic [REC_W-1:0] RECURSION_QUOTA_RESET = 7'd100;
   localparam logic [BYTE_W-1:0] STACK_BYTE_QUOTA_RESET = 32'd65536;
   localparam logic [BYTE_W-1:0] RETAINED_BYTE_QUOTA_RESET = 32'd65536;
   localparam logic INTERRUPT_ENABLE_RESET = 1'b0;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_STEP = 4'd0,
      FUNC_LOOP = 4'd1,
      FUNC_CB_BEFORE = 4'd2,
      FUNC_CB_AFTER = 4'd3,
      FUNC_ENTER = 4'd4,
      FUNC_LEAVE = 4'd5,
      FUNC_RETAINED = 4'd6,
      FUNC_BEGIN = 4'd7
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_LIMIT = 2'd1,
      STATUS_INTERRUPTED = 2'd2,
      STATUS_INVALID = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PHASE_NONE = 2'd0,
      PHASE_CALL = 2'd1,
      PHASE_INTERRUPT = 2'd2
   } phase_type;

   typedef enum logic [3:0] {
      REASON_NONE = 4'd0,
      REASON_STEP = 4'd1,
      REASON_LOOP = 4'd2,
      REASON_CALLBACK = 4'd3,
      REASON_RECURSION = 4'd4,
      REASON_STACK = 4'd5,
      REASON_RETAINED = 4'd6,
      REASON_INTERRUPT = 4'd7,
      REASON_ACCOUNTING = 4'd8,
      REASON_BAD_KIND = 4'd9
   } reason_type;

   typedef enum logic [2:0] {
      REG_STEP_QUOTA = 3'd0,
      REG_LOOP_QUOTA = 3'd1,
      REG_CALLBACK_QUOTA = 3'd2,
      REG_RECURSION_QUOTA = 3'd3,
      REG_STACK_BYTE_QUOTA = 3'd4,
      REG_RETAINED_BYTE_QUOTA = 3'd5,
      REG_INTERRUPT_ENABLE = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [STEP_W-1:0] step_quota;
      logic [LOOP_W-1:0] loop_quota;
      logic [CB_W-1:0] callback_quota;
      logic [REC_W-1:0] recursion_quota;
      logic [BYTE_W-1:0] stack_byte_quota;
      logic [BYTE_W-1:0] retained_byte_quota;
      logic interrupt_enable;
   } cfg_type;

   typedef struct packed {
      func_type func;
      logic [COST_W-1:0] cost;
      logic interrupt_request;
   } item_type;

   typedef struct packed {
      logic ok;
      status_type status;
      phase_type phase;
      reason_type reason;
      logic polled;
   } result_type;

endpackage

// ===== hw/rtl/execution_budget_monitor.sv =====
// A word accepted on the req_ channel is held in the input register, processed by the core
// and placed in the result register, where it waits until the receiver takes it.
// Throughput: one word per cycle while rsp_stall is low; the core updates its budget state
// in the same cycle that it processes a word, so each word sees the state left by the one before it.
// Reset (synchronous, active high): registers and budgets take their reset values and the
// sticky failure record clears. Register writes act at the next begin-call event.
module execution_budget_monitor #(
   parameter int unsigned POLL_INTERVAL = ebm_pkg::POLL_INTERVAL_DEFAULT
) (
   input  logic clock,
   input  logic reset,

   input  logic req_valid,
   output logic req_stall,
   input  logic [ebm_pkg::FUNC_W-1:0] req_func,
   input  logic [ebm_pkg::COST_W-1:0] req_cost,
   input  logic req_interrupt_request,

   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_ok,
   output logic [1:0] rsp_failure_status,
   output logic [1:0] rsp_failure_phase,
   output logic [3:0] rsp_failure_reason,
   output logic rsp_interrupt_polled,

   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [ebm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [ebm_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ebm_pkg::CSR_DATA_W-1:0] prdata,
   output logic pready
);
   import ebm_pkg::*;

   // Input register: holds one word until the core can process it.
   logic in_valid_ff;
   item_type in_item_ff;

   // Result register: holds one result until the downstream side takes it.
   logic rsp_valid_ff;
   result_type rsp_ff;

   logic advance;
   logic fire;
   cfg_type cfg;
   result_type core_result;

   // The result register can load whenever it is empty or being drained this cycle.
   // The input register then moves its word into the core, which frees it for a new one,
   // so the two stages run back to back without bubbles.
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign fire = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   // Payload registers carry no reset; the valid bits qualify them.
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_item_ff.func <= func_type'(req_func);
         in_item_ff.cost <= req_cost;
         in_item_ff.interrupt_request <= req_interrupt_request;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= fire;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= core_result;
      end
   end

   ebm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The core holds all budget and failure state and updates it in the same cycle
   // that it produces the result for the word at the head of the input register.
   ebm_core #(
      .POLL_INTERVAL (POLL_INTERVAL)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (core_result)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ok = rsp_ff.ok;
   assign rsp_failure_status = rsp_ff.status;
   assign rsp_failure_phase = rsp_ff.phase;
   assign rsp_failure_reason = rsp_ff.reason;
   assign rsp_interrupt_polled = rsp_ff.polled;

   // An accepted word means there was no failure recorded at that point.
   a_ok_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.ok |-> rsp_ff.status == STATUS_OK)
      else $error("result accepted while a failure is recorded");

   // A word that reaches the core while the result register is free or draining must come out next cycle.
   a_fire_to_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid_ff)
      else $error("processed word did not reach the result register");

endmodule

// ===== hw/rtl/ebm_csr.sv =====
module ebm_csr (
   input  logic clock,
   input  logic reset,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [ebm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [ebm_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ebm_pkg::CSR_DATA_W-1:0] prdata,
   output logic pready,
   output ebm_pkg::cfg_type cfg
);
   import ebm_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   reg_index_type index;
   logic write_en;

   assign pready = 1'b1;
   assign index = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign write_en = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      prdata = '0;
      case (index)
         REG_STEP_QUOTA: begin
            prdata = CSR_DATA_W'(cfg_ff.step_quota);
            if (write_en) cfg_in.step_quota = pwdata[STEP_W-1:0];
         end
         REG_LOOP_QUOTA: begin
            prdata = CSR_DATA_W'(cfg_ff.loop_quota);
            if (write_en) cfg_in.loop_quota = pwdata[LOOP_W-1:0];
         end
         REG_CALLBACK_QUOTA: begin
            prdata = CSR_DATA_W'(cfg_ff.callback_quota);
            if (write_en) cfg_in.callback_quota = pwdata[CB_W-1:0];
         end
         REG_RECURSION_QUOTA: begin
            prdata = CSR_DATA_W'(cfg_ff.recursion_quota);
            if (write_en) cfg_in.recursion_quota = pwdata[REC_W-1:0];
         end
         REG_STACK_BYTE_QUOTA: begin
            prdata = CSR_DATA_W'(cfg_ff.stack_byte_quota);
            if (write_en) cfg_in.stack_byte_quota = pwdata[BYTE_W-1:0];
         end
         REG_RETAINED_BYTE_QUOTA: begin
            prdata = CSR_DATA_W'(cfg_ff.retained_byte_quota);
            if (write_en) cfg_in.retained_byte_quota = pwdata[BYTE_W-1:0];
         end
         REG_INTERRUPT_ENABLE: begin
            prdata = CSR_DATA_W'(cfg_ff.interrupt_enable);
            if (write_en) cfg_in.interrupt_enable = pwdata[0];
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_quota <= STEP_QUOTA_RESET;
         cfg_ff.loop_quota <= LOOP_QUOTA_RESET;
         cfg_ff.callback_quota <= CALLBACK_QUOTA_RESET;
         cfg_ff.recursion_quota <= RECURSION_QUOTA_RESET;
         cfg_ff.stack_byte_quota <= STACK_BYTE_QUOTA_RESET;
         cfg_ff.retained_byte_quota <= RETAINED_BYTE_QUOTA_RESET;
         cfg_ff.interrupt_enable <= INTERRUPT_ENABLE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/ebm_core.sv =====
module ebm_core #(
   parameter int unsigned POLL_INTERVAL = ebm_pkg::POLL_INTERVAL_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic fire,
   input  ebm_pkg::item_type item,
   input  ebm_pkg::cfg_type cfg,
   output ebm_pkg::result_type result
);
   import ebm_pkg::*;

   localparam int unsigned CntW = (POLL_INTERVAL > 1) ? $clog2(POLL_INTERVAL) : 1;
   localparam logic [CntW:0] PollLimit = POLL_INTERVAL[CntW:0];

   logic [STEP_W-1:0] steps_remaining_ff, steps_remaining_in;
   logic [LOOP_W-1:0] loops_remaining_ff, loops_remaining_in;
   logic [CB_W-1:0] callbacks_remaining_ff, callbacks_remaining_in;
   logic [REC_W-1:0] recursion_remaining_ff, recursion_remaining_in;
   logic [REC_W-1:0] recursion_limit_ff, recursion_limit_in;
   logic [BYTE_W-1:0] stack_remaining_ff, stack_remaining_in;
   logic [BYTE_W-1:0] stack_limit_ff, stack_limit_in;
   logic [BYTE_W-1:0] retained_limit_ff, retained_limit_in;
   logic poll_enabled_ff, poll_enabled_in;
   logic [CntW-1:0] poll_count_ff, poll_count_in;
   status_type sticky_status_ff, sticky_status_in;
   phase_type sticky_phase_ff, sticky_phase_in;
   reason_type sticky_reason_ff, sticky_reason_in;

   logic [CntW:0] poll_room;
   logic do_poll;
   logic fail_now;
   logic polled;
   logic ok;
   status_type fail_status;
   phase_type fail_phase;
   reason_type fail_reason;

   assign poll_room = PollLimit - {1'b0, poll_count_ff};

   always_comb begin
      steps_remaining_in = steps_remaining_ff;
      loops_remaining_in = loops_remaining_ff;
      callbacks_remaining_in = callbacks_remaining_ff;
      recursion_remaining_in = recursion_remaining_ff;
      recursion_limit_in = recursion_limit_ff;
      stack_remaining_in = stack_remaining_ff;
      stack_limit_in = stack_limit_ff;
      retained_limit_in = retained_limit_ff;
      poll_enabled_in = poll_enabled_ff;
      poll_count_in = poll_count_ff;
      sticky_status_in = sticky_status_ff;
      sticky_phase_in = sticky_phase_ff;
      sticky_reason_in = sticky_reason_ff;
      do_poll = 1'b0;
      fail_now = 1'b0;
      polled = 1'b0;
      ok = 1'b1;
      fail_status = STATUS_LIMIT;
      fail_phase = PHASE_CALL;
      fail_reason = REASON_NONE;

      if (fire) begin
         if (item.func == FUNC_BEGIN) begin
            // Reload every budget from the registers and drop any failure.
            steps_remaining_in = (cfg.step_quota > CAP_STEP) ? CAP_STEP : cfg.step_quota;
            loops_remaining_in = (cfg.loop_quota > CAP_LOOP) ? CAP_LOOP : cfg.loop_quota;
            callbacks_remaining_in = (cfg.callback_quota > CAP_CALLBACK) ?
                                     CAP_CALLBACK : cfg.callback_quota;
            recursion_remaining_in = (cfg.recursion_quota > CAP_RECURSION) ?
                                     CAP_RECURSION : cfg.recursion_quota;
            recursion_limit_in = recursion_remaining_in;
            stack_remaining_in = cfg.stack_byte_quota;
            stack_limit_in = cfg.stack_byte_quota;
            retained_limit_in = cfg.retained_byte_quota;
            poll_enabled_in = cfg.interrupt_enable;
            poll_count_in = '0;
            sticky_status_in = STATUS_OK;
            sticky_phase_in = PHASE_NONE;
            sticky_reason_in = REASON_NONE;
         end else if (sticky_status_ff != STATUS_OK) begin
            ok = 1'b0;
         end else begin
            case (item.func)
               FUNC_STEP: begin
                  if (BYTE_W'(steps_remaining_ff) < item.cost) begin
                     fail_now = 1'b1;
                     fail_reason = REASON_STEP;
                  end else begin
                     steps_remaining_in = steps_remaining_ff - item.cost[STEP_W-1:0];
                     if (item.cost >= COST_W'(poll_room)) begin
                        poll_count_in = '0;
                        do_poll = 1'b1;
                     end else begin
                        poll_count_in = poll_count_ff + item.cost[CntW-1:0];
                     end
                  end
               end
               FUNC_LOOP: begin
                  if (COST_W'(loops_remaining_ff) < item.cost) begin
                     fail_now = 1'b1;
                     fail_reason = REASON_LOOP;
                  end else begin
                     loops_remaining_in = loops_remaining_ff - item.cost[LOOP_W-1:0];
                     do_poll = 1'b1;
                  end
               end
               FUNC_CB_BEFORE: begin
                  if (COST_W'(callbacks_remaining_ff) < item.cost) begin
                     fail_now = 1'b1;
                     fail_reason = REASON_CALLBACK;
                  end else begin
                     callbacks_remaining_in = callbacks_remaining_ff - item.cost[CB_W-1:0];
                     do_poll = 1'b1;
                  end
               end
               FUNC_CB_AFTER: begin
                  do_poll = 1'b1;
               end
               FUNC_ENTER: begin
                  if (recursion_remaining_ff == '0) begin
                     fail_now = 1'b1;
                     fail_reason = REASON_RECURSION;
                  end else if (stack_remaining_ff < item.cost) begin
                     fail_now = 1'b1;
                     fail_reason = REASON_STACK;
                  end else begin
                     recursion_remaining_in = recursion_remaining_ff - 1'b1;
                     stack_remaining_in = stack_remaining_ff - item.cost;
                     do_poll = 1'b1;
                  end
               end
               FUNC_LEAVE: begin
                  // The frame being released must fit inside what was charged.
                  if ((item.cost > stack_limit_ff) ||
                      (recursion_remaining_ff >= recursion_limit_ff) ||
                      (stack_remaining_ff > (stack_limit_ff - item.cost))) begin
                     fail_now = 1'b1;
                     fail_status = STATUS_INVALID;
                     fail_reason = REASON_ACCOUNTING;
                  end else begin
                     recursion_remaining_in = recursion_remaining_ff + 1'b1;
                     stack_remaining_in = stack_remaining_ff + item.cost;
                  end
               end
               FUNC_RETAINED: begin
                  if (item.cost > retained_limit_ff) begin
                     fail_now = 1'b1;
                     fail_reason = REASON_RETAINED;
                  end
               end
               default: begin
                  fail_now = 1'b1;
                  fail_status = STATUS_INVALID;
                  fail_reason = REASON_BAD_KIND;
               end
            endcase

            if (do_poll && poll_enabled_ff) begin
               polled = 1'b1;
               if (item.interrupt_request) begin
                  fail_now = 1'b1;
                  fail_status = STATUS_INTERRUPTED;
                  fail_phase = PHASE_INTERRUPT;
                  fail_reason = REASON_INTERRUPT;
               end
            end

            if (fail_now) begin
               ok = 1'b0;
               sticky_status_in = fail_status;
               sticky_phase_in = fail_phase;
               sticky_reason_in = fail_reason;
            end
         end
      end

      result.ok = ok;
      result.status = sticky_status_in;
      result.phase = sticky_phase_in;
      result.reason = sticky_reason_in;
      result.polled = polled;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_remaining_ff <= STEP_QUOTA_RESET;
         loops_remaining_ff <= LOOP_QUOTA_RESET;
         callbacks_remaining_ff <= CALLBACK_QUOTA_RESET;
         recursion_remaining_ff <= RECURSION_QUOTA_RESET;
         recursion_limit_ff <= RECURSION_QUOTA_RESET;
         stack_remaining_ff <= STACK_BYTE_QUOTA_RESET;
         stack_limit_ff <= STACK_BYTE_QUOTA_RESET;
         retained_limit_ff <= RETAINED_BYTE_QUOTA_RESET;
         poll_enabled_ff <= INTERRUPT_ENABLE_RESET;
         poll_count_ff <= '0;
         sticky_status_ff <= STATUS_OK;
         sticky_phase_ff <= PHASE_NONE;
         sticky_reason_ff <= REASON_NONE;
      end else begin
         steps_remaining_ff <= steps_remaining_in;
         loops_remaining_ff <= loops_remaining_in;
         callbacks_remaining_ff <= callbacks_remaining_in;
         recursion_remaining_ff <= recursion_remaining_in;
         recursion_limit_ff <= recursion_limit_in;
         stack_remaining_ff <= stack_remaining_in;
         stack_limit_ff <= stack_limit_in;
         retained_limit_ff <= retained_limit_in;
         poll_enabled_ff <= poll_enabled_in;
         poll_count_ff <= poll_count_in;
         sticky_status_ff <= sticky_status_in;
         sticky_phase_ff <= sticky_phase_in;
         sticky_reason_ff <= sticky_reason_in;
      end
   end

   a_sticky_clean: assert property (@(posedge clock) disable iff (reset)
      sticky_status_ff == STATUS_OK |->
         sticky_phase_ff == PHASE_NONE && sticky_reason_ff == REASON_NONE)
      else $error("failure phase or reason set without a failure status");

   a_poll_count_range: assert property (@(posedge clock) disable iff (reset)
      32'(poll_count_ff) < POLL_INTERVAL)
      else $error("step poll count reached the poll interval");

   a_recursion_bound: assert property (@(posedge clock) disable iff (reset)
      recursion_remaining_ff <= recursion_limit_ff && stack_remaining_ff <= stack_limit_ff)
      else $error("released more recursion depth or stack than was charged");

endmodule

// ===== tb/ebm_budget_checker.sv =====
module ebm_budget_checker #(
   parameter int unsigned POLL_INTERVAL = ebm_pkg::POLL_INTERVAL_DEFAULT
) (
   input  logic clock,
   input  logic reset,

   input  logic req_valid,
   input  logic req_stall,
   input  logic [ebm_pkg::FUNC_W-1:0] req_func,
   input  logic [ebm_pkg::COST_W-1:0] req_cost,
   input  logic req_interrupt_request,

   input  logic rsp_valid,
   input  logic rsp_stall,
   input  logic rsp_ok,
   input  logic [1:0] rsp_failure_status,
   input  logic [1:0] rsp_failure_phase,
   input  logic [3:0] rsp_failure_reason,
   input  logic rsp_interrupt_polled,

   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [ebm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [ebm_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic pready,

   output int unsigned mismatch_count,
   output int unsigned pending_words
);
   timeunit 1ns;
   timeprecision 1ps;
   import ebm_pkg::*;

   // Register copy, as written over the bus.
   cfg_type quotas;

   // Budgets and limits latched at the last begin-call.
   logic [STEP_W-1:0] step_budget;
   logic [LOOP_W-1:0] loop_budget;
   logic [CB_W-1:0] callback_budget;
   logic [REC_W-1:0] depth_left;
   logic [REC_W-1:0] depth_limit;
   logic [BYTE_W-1:0] stack_left;
   logic [BYTE_W-1:0] stack_limit;
   logic [BYTE_W-1:0] retained_limit;
   logic poll_on;
   logic [COST_W-1:0] poll_count;

   status_type fail_status;
   phase_type fail_phase;
   reason_type fail_reason;

   result_type expected_outcomes[$];
   int unsigned result_count;

   task automatic report_mismatch(input string what);
      $display("[%0t] result %0d: %s", $realtime, result_count, what);
      mismatch_count++;
   endtask

   function automatic void load_budgets();
      step_budget = (quotas.step_quota < CAP_STEP) ? quotas.step_quota : CAP_STEP;
      loop_budget = (quotas.loop_quota < CAP_LOOP) ? quotas.loop_quota : CAP_LOOP;
      callback_budget = (quotas.callback_quota < CAP_CALLBACK) ?
                        quotas.callback_quota : CAP_CALLBACK;
      depth_left = (quotas.recursion_quota < CAP_RECURSION) ?
                   quotas.recursion_quota : CAP_RECURSION;
      depth_limit = depth_left;
      stack_left = quotas.stack_byte_quota;
      stack_limit = quotas.stack_byte_quota;
      retained_limit = quotas.retained_byte_quota;
      poll_on = quotas.interrupt_enable;
      poll_count = '0;
      fail_status = STATUS_OK;
      fail_phase = PHASE_NONE;
      fail_reason = REASON_NONE;
   endfunction

   function automatic void reset_model();
      quotas.step_quota = STEP_QUOTA_RESET;
      quotas.loop_quota = LOOP_QUOTA_RESET;
      quotas.callback_quota = CALLBACK_QUOTA_RESET;
      quotas.recursion_quota = RECURSION_QUOTA_RESET;
      quotas.stack_byte_quota = STACK_BYTE_QUOTA_RESET;
      quotas.retained_byte_quota = RETAINED_BYTE_QUOTA_RESET;
      quotas.interrupt_enable = INTERRUPT_ENABLE_RESET;
      load_budgets();
   endfunction

   function automatic void write_register(input reg_index_type idx,
                                          input logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_STEP_QUOTA: quotas.step_quota = data[STEP_W-1:0];
         REG_LOOP_QUOTA: quotas.loop_quota = data[LOOP_W-1:0];
         REG_CALLBACK_QUOTA: quotas.callback_quota = data[CB_W-1:0];
         REG_RECURSION_QUOTA: quotas.recursion_quota = data[REC_W-1:0];
         REG_STACK_BYTE_QUOTA: quotas.stack_byte_quota = data[BYTE_W-1:0];
         REG_RETAINED_BYTE_QUOTA: quotas.retained_byte_quota = data[BYTE_W-1:0];
         REG_INTERRUPT_ENABLE: quotas.interrupt_enable = data[0];
         default: ;
      endcase
   endfunction

   // Only the first failure after a begin-call is kept.
   function automatic void record_failure(input status_type s, input phase_type p,
                                          input reason_type r);
      if (fail_status == STATUS_OK) begin
         fail_status = s;
         fail_phase = p;
         fail_reason = r;
      end
   endfunction

   function automatic logic poll_interrupt(input logic irq, output logic polled);
      polled = poll_on;
      if (poll_on && irq) begin
         record_failure(STATUS_INTERRUPTED, PHASE_INTERRUPT, REASON_INTERRUPT);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic result_type predict_outcome(input item_type w);
      result_type r;
      logic [COST_W-1:0] room;
      logic ok;
      logic polled;
      ok = 1'b1;
      polled = 1'b0;
      if (w.func == FUNC_BEGIN) begin
         load_budgets();
      end else if (fail_status != STATUS_OK) begin
         ok = 1'b0;
      end else begin
         case (w.func)
            FUNC_STEP: begin
               if (step_budget < w.cost) begin
                  record_failure(STATUS_LIMIT, PHASE_CALL, REASON_STEP);
                  ok = 1'b0;
               end else begin
                  step_budget -= STEP_W'(w.cost);
                  room = POLL_INTERVAL - poll_count;
                  if (w.cost >= room) begin
                     poll_count = '0;
                     ok = poll_interrupt(w.interrupt_request, polled);
                  end else begin
                     poll_count += w.cost;
                  end
               end
            end
            FUNC_LOOP: begin
               if (loop_budget < w.cost) begin
                  record_failure(STATUS_LIMIT, PHASE_CALL, REASON_LOOP);
                  ok = 1'b0;
               end else begin
                  loop_budget -= LOOP_W'(w.cost);
                  ok = poll_interrupt(w.interrupt_request, polled);
               end
            end
            FUNC_CB_BEFORE: begin
               if (callback_budget < w.cost) begin
                  record_failure(STATUS_LIMIT, PHASE_CALL, REASON_CALLBACK);
                  ok = 1'b0;
               end else begin
                  callback_budget -= CB_W'(w.cost);
                  ok = poll_interrupt(w.interrupt_request, polled);
               end
            end
            FUNC_CB_AFTER: ok = poll_interrupt(w.interrupt_request, polled);
            FUNC_ENTER: begin
               if (depth_left == '0) begin
                  record_failure(STATUS_LIMIT, PHASE_CALL, REASON_RECURSION);
                  ok = 1'b0;
               end else if (stack_left < w.cost) begin
                  record_failure(STATUS_LIMIT, PHASE_CALL, REASON_STACK);
                  ok = 1'b0;
               end else begin
                  depth_left--;
                  stack_left -= w.cost;
                  ok = poll_interrupt(w.interrupt_request, polled);
               end
            end
            FUNC_LEAVE: begin
               if (w.cost > stack_limit || depth_left >= depth_limit ||
                   stack_left > stack_limit - w.cost) begin
                  record_failure(STATUS_INVALID, PHASE_CALL, REASON_ACCOUNTING);
                  ok = 1'b0;
               end else begin
                  depth_left++;
                  stack_left += w.cost;
               end
            end
            FUNC_RETAINED: begin
               if (w.cost > retained_limit) begin
                  record_failure(STATUS_LIMIT, PHASE_CALL, REASON_RETAINED);
                  ok = 1'b0;
               end
            end
            default: begin
               record_failure(STATUS_INVALID, PHASE_CALL, REASON_BAD_KIND);
               ok = 1'b0;
            end
         endcase
      end
      r.ok = ok;
      r.status = fail_status;
      r.phase = fail_phase;
      r.reason = fail_reason;
      r.polled = polled;
      return r;
   endfunction

   always @(posedge clock) begin
      result_type seen;
      result_type want;
      item_type word;
      if (reset) begin
         reset_model();
         expected_outcomes.delete();
         result_count = 0;
         mismatch_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen.ok = rsp_ok;
            seen.status = status_type'(rsp_failure_status);
            seen.phase = phase_type'(rsp_failure_phase);
            seen.reason = reason_type'(rsp_failure_reason);
            seen.polled = rsp_interrupt_polled;
            result_count++;
            if (expected_outcomes.size() == 0) begin
               report_mismatch("result word with nothing outstanding");
            end else begin
               want = expected_outcomes.pop_front();
               if (seen.ok != want.ok)
                  report_mismatch($sformatf("ok %0d, expected %0d", seen.ok, want.ok));
               if (seen.status != want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            seen.status, want.status));
               if (seen.phase != want.phase)
                  report_mismatch($sformatf("phase %0d, expected %0d",
                                            seen.phase, want.phase));
               if (seen.reason != want.reason)
                  report_mismatch($sformatf("reason %0d, expected %0d",
                                            seen.reason, want.reason));
               if (seen.polled != want.polled)
                  report_mismatch($sformatf("interrupt_polled %0d, expected %0d",
                                            seen.polled, want.polled));
            end
         end
         if (req_valid && !req_stall) begin
            word.func = func_type'(req_func);
            word.cost = req_cost;
            word.interrupt_request = req_interrupt_request;
            expected_outcomes.push_back(predict_outcome(word));
         end
         if (psel && penable && pwrite && pready)
            write_register(reg_index_type'(paddr[CSR_ADDR_W-1:2]), pwdata);
      end
      pending_words <= expected_outcomes.size();
   end

endmodule

// ===== tb/tb_execution_budget_monitor.sv =====
module tb_execution_budget_monitor;
   timeunit 1ns;
   timeprecision 1ps;
   import ebm_pkg::*;

   // The block answers through its input and result registers; the settling
   // time adds slack for a result register that is held by the receiver.
   localparam int unsigned SETTLE_CYCLES = 6;
   // Bound on a stretch with no word moving on either channel; a correct
   // block shows them only in sender gaps, stalls, register writes and settling.
   localparam int unsigned IDLE_LIMIT = 2000;
   localparam int unsigned RANDOM_PHASES = 6;
   localparam int unsigned WORDS_PER_PHASE = 103;

   // How a phase chooses its register values.
   typedef enum {CFG_MAX, CFG_MIN, CFG_RANDOM} cfg_style_type;
   // How the result receiver holds off the block.
   typedef enum {RX_FLOWING, RX_RANDOM, RX_PERIODIC} stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic req_valid = 1'b0;
   logic req_stall;
   logic [FUNC_W-1:0] req_func = '0;
   logic [COST_W-1:0] req_cost = '0;
   logic req_interrupt_request = 1'b0;

   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_ok;
   logic [1:0] rsp_failure_status;
   logic [1:0] rsp_failure_phase;
   logic [3:0] rsp_failure_reason;
   logic rsp_interrupt_polled;

   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   int unsigned mismatch_count;
   int unsigned pending_words;

   // Sender shaping: words go out in bursts; a steady phase opens every burst without a gap.
   int unsigned burst_left = 0;
   bit sender_steady = 1'b0;
   int unsigned irq_odds = 20;

   // Stack bytes of every frame entered since the last begin-call, so that
   // leave words normally hand back exactly what was charged.
   logic [COST_W-1:0] frame_costs[$];

   always #2 clock = ~clock;

   execution_budget_monitor DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_cost(req_cost),
      .req_interrupt_request(req_interrupt_request),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_ok(rsp_ok),
      .rsp_failure_status(rsp_failure_status),
      .rsp_failure_phase(rsp_failure_phase),
      .rsp_failure_reason(rsp_failure_reason),
      .rsp_interrupt_polled(rsp_interrupt_polled),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   ebm_budget_checker checker_inst (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_cost(req_cost),
      .req_interrupt_request(req_interrupt_request),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_ok(rsp_ok),
      .rsp_failure_status(rsp_failure_status),
      .rsp_failure_phase(rsp_failure_phase),
      .rsp_failure_reason(rsp_failure_reason),
      .rsp_interrupt_polled(rsp_interrupt_polled),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .pready(pready),
      .mismatch_count(mismatch_count),
      .pending_words(pending_words)
   );

   // The receiver switches at random among three stall patterns: no stalls
   // at all, a random stall with odds of one in three, and a fixed duty cycle.
   // This puts holds on every phase of the block's two-stage pipeline.
   stall_mode_type stall_mode = RX_FLOWING;
   int unsigned stall_left = 0;

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 2));
         stall_left = $urandom_range(20, 120);
      end else begin
         stall_left--;
      end
      case (stall_mode)
         RX_FLOWING: rsp_stall <= 1'b0;
         RX_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
         default: rsp_stall <= (stall_left % 16) < 9;
      endcase
   end

   // Watchdog: a run in which nothing moves for too long has hung.
   int unsigned idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable && pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_execution_budget_monitor failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // One bus write: a setup phase, then the access phase, which completes at
   // the edge where pready is seen high.
   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // Stops the sender and waits until every word sent so far has been
   // answered. The first edge lets the checker count the last accepted word.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Presents one word and returns in the time step of the edge that takes it.
   // Valid stays high, so the next word follows without a bubble unless a new
   // burst opens with a gap.
   task automatic send_word(input logic [FUNC_W-1:0] func, input logic [COST_W-1:0] cost,
                            input logic irq);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = sender_steady ? 0 : $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_func <= func;
      req_cost <= cost;
      req_interrupt_request <= irq;
      do @(posedge clock); while (req_stall);
   endtask

   // Register values: the extremes of the field, uniform noise over the
   // field, or values near a size at which the budgets run out now and then.
   function automatic logic [CSR_DATA_W-1:0] quota_for(input cfg_style_type style,
                                                       input int unsigned width,
                                                       input int unsigned typical);
      logic [CSR_DATA_W-1:0] mask;
      mask = (width >= 32) ? 32'hFFFF_FFFF : (32'h1 << width) - 32'h1;
      if (style == CFG_MAX) return mask;
      if (style == CFG_MIN) return '0;
      case ($urandom_range(0, 9))
         0: return '0;
         1: return mask;
         2, 3: return $urandom & mask;
         default: return $urandom_range(typical / 2, typical * 2) & mask;
      endcase
   endfunction

   task automatic load_config(input cfg_style_type style);
      csr_write(REG_STEP_QUOTA, quota_for(style, STEP_W, 400));
      csr_write(REG_LOOP_QUOTA, quota_for(style, LOOP_W, 60));
      csr_write(REG_CALLBACK_QUOTA, quota_for(style, CB_W, 12));
      csr_write(REG_RECURSION_QUOTA, quota_for(style, REC_W, 6));
      csr_write(REG_STACK_BYTE_QUOTA, quota_for(style, BYTE_W, 6000));
      csr_write(REG_RETAINED_BYTE_QUOTA, quota_for(style, BYTE_W, 3000));
      csr_write(REG_INTERRUPT_ENABLE, quota_for(style, 1, 1));
   endtask

   // Mostly small charges, with the odd zero and the odd full-width value so
   // that the high cost bits toggle and the limit checks fire.
   function automatic logic [COST_W-1:0] pick_cost(input int unsigned typical);
      case ($urandom_range(0, 19))
         0: return $urandom;
         1: return '0;
         default: return $urandom_range(0, typical);
      endcase
   endfunction

   // One word of a program run. Enter and leave are kept balanced so that
   // runs get deep; a small share of leaves, invalid kinds and stray
   // begin-calls break the run on purpose.
   task automatic send_random_word();
      int unsigned pick;
      logic irq;
      logic [COST_W-1:0] cost;
      pick = $urandom_range(0, 99);
      irq = ($urandom_range(0, irq_odds) == 0);
      if (pick < 30) begin
         send_word(FUNC_STEP, pick_cost(($urandom_range(0, 7) == 0) ? 300 : 40), irq);
      end else if (pick < 42) begin
         send_word(FUNC_LOOP, pick_cost(20), irq);
      end else if (pick < 52) begin
         send_word(FUNC_CB_BEFORE, pick_cost(3), irq);
      end else if (pick < 60) begin
         send_word(FUNC_CB_AFTER, $urandom, irq);
      end else if (pick < 72) begin
         cost = pick_cost(1200);
         frame_costs.push_back(cost);
         send_word(FUNC_ENTER, cost, irq);
      end else if (pick < 84) begin
         if (frame_costs.size() != 0 && $urandom_range(0, 15) != 0)
            cost = frame_costs.pop_back();
         else
            cost = pick_cost(2000);
         send_word(FUNC_LEAVE, cost, irq);
      end else if (pick < 92) begin
         send_word(FUNC_RETAINED, pick_cost(4000), irq);
      end else if (pick < 97) begin
         frame_costs.delete();
         send_word(FUNC_BEGIN, $urandom, irq);
      end else begin
         send_word(FUNC_W'($urandom_range(8, 15)), $urandom, irq);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed words on the reset register values. The interrupt is not
      // polled yet, so interrupt requests must be ignored, and the retained,
      // bad-kind, accounting, stack and step failures are provoked once each,
      // each followed by a begin-call that clears the sticky record.
      send_word(FUNC_BEGIN, 32'hFFFF_FFFF, 1'b1);
      send_word(FUNC_STEP, 32'd0, 1'b0);
      send_word(FUNC_STEP, 32'd256, 1'b1);
      send_word(FUNC_LOOP, 32'd1, 1'b0);
      send_word(FUNC_CB_BEFORE, 32'd1, 1'b0);
      send_word(FUNC_CB_AFTER, 32'd0, 1'b1);
      send_word(FUNC_ENTER, 32'd65536, 1'b0);
      send_word(FUNC_LEAVE, 32'd65536, 1'b0);
      send_word(FUNC_RETAINED, 32'd65536, 1'b0);
      // One byte over the retained limit fails, and the next word is refused.
      send_word(FUNC_RETAINED, 32'd65537, 1'b0);
      send_word(FUNC_STEP, 32'd1, 1'b0);
      send_word(FUNC_BEGIN, 32'd0, 1'b0);
      send_word(4'hF, 32'd0, 1'b0);
      send_word(FUNC_BEGIN, 32'd0, 1'b0);
      // A leave with no frame entered is an accounting error.
      send_word(FUNC_LEAVE, 32'd0, 1'b0);
      send_word(FUNC_BEGIN, 32'd0, 1'b0);
      send_word(FUNC_ENTER, 32'd65537, 1'b0);
      send_word(FUNC_BEGIN, 32'd0, 1'b0);
      send_word(FUNC_STEP, 32'hFFFF_FFFF, 1'b0);
      drain();

      // No recursion allowed and the interrupt polled: the first enter fails
      // on depth, and the step poll fires exactly when the count reaches the
      // polling interval.
      csr_write(REG_RECURSION_QUOTA, 32'd0);
      csr_write(REG_INTERRUPT_ENABLE, 32'd1);
      send_word(FUNC_BEGIN, 32'd0, 1'b0);
      send_word(FUNC_ENTER, 32'd0, 1'b0);
      send_word(FUNC_BEGIN, 32'd0, 1'b0);
      send_word(FUNC_STEP, 32'd255, 1'b1);
      send_word(FUNC_STEP, 32'd1, 1'b1);
      send_word(FUNC_BEGIN, 32'd0, 1'b0);
      send_word(FUNC_LOOP, 32'd0, 1'b0);
      send_word(FUNC_CB_AFTER, 32'd0, 1'b1);
      drain();

      // Random phases: the first with every register at its largest value,
      // the second with all of them at zero, the rest drawn at random. Each
      // phase starts a fresh run with a begin-call.
      for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 0)
            load_config(CFG_MAX);
         else if (phase == 1)
            load_config(CFG_MIN);
         else
            load_config(CFG_RANDOM);
         sender_steady = ($urandom_range(0, 3) == 0);
         irq_odds = $urandom_range(8, 80);
         burst_left = 0;
         frame_costs.delete();
         send_word(FUNC_BEGIN, $urandom, 1'($urandom_range(0, 1)));
         for (int unsigned n = 0; n < WORDS_PER_PHASE; n++) begin
            send_random_word();
            // Now and then the sender holds off until the block is empty.
            if ($urandom_range(0, 49) == 0) drain();
         end
         drain();
      end

      if (mismatch_count == 0)
         $display("tb_execution_budget_monitor passed");
      else
         $display("tb_execution_budget_monitor failed");
      $finish;
   end

endmodule
